>>> sv/assembler_source_lexer_assert.svh
// Assertion macros shared by the lexer RTL.
`ifndef ASSEMBLER_SOURCE_LEXER_ASSERT_SVH
`define ASSEMBLER_SOURCE_LEXER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ASL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/asl_pkg.sv
// Shared types and codes for the assembler source lexer.
package asl_pkg;

    // Token kinds on the result stream
    typedef enum logic [3:0] {
        TK_EOF     = 4'd0,
        TK_NUMBER  = 4'd1,
        TK_WCHAR   = 4'd2,
        TK_WEND    = 4'd3,
        TK_COMMA   = 4'd4,
        TK_COLON   = 4'd5,
        TK_GREATER = 4'd6,
        TK_LESS    = 4'd7,
        TK_POUND   = 4'd8,
        TK_LPAREN  = 4'd9,
        TK_RPAREN  = 4'd10,
        TK_DOT     = 4'd11,
        TK_NEWLINE = 4'd12,
        TK_ERROR   = 4'd13
    } t_tok_kind;

    // Lexer modes
    typedef enum logic [2:0] {
        LM_IDLE = 3'd0,
        LM_DEC  = 3'd1,
        LM_HEX  = 3'd2,
        LM_WORD = 3'd3,
        LM_CR   = 3'd4
    } t_lex_mode;

    localparam int unsigned VALUE_W = 16;
    localparam int unsigned LINE_W  = 16;
    localparam int unsigned COUNT_W = 7;

    // One result item
    typedef struct packed {
        t_tok_kind          kind;
        logic [VALUE_W-1:0] value;
        logic [LINE_W-1:0]  line;
        logic               last;
    } t_result;

    // Results of one input beat: up to two
    typedef struct packed {
        logic [1:0]        cnt;
        t_result [1:0]     res;
    } t_pair;

endpackage

>>> sv/asl_lex_core.sv
// Lexer state and the per-byte classify-and-accumulate step.
module asl_lex_core #(
    parameter int MAX_TOKEN_CHARS = 79
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,      // commit the current beat
    input  logic           i_req_eof,   // end of input
    input  logic [7:0]     i_byte,
    output asl_pkg::t_pair o_pair       // results of the current beat
);

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_POUND  = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [asl_pkg::COUNT_W-1:0] MAX_CNT = asl_pkg::COUNT_W'(MAX_TOKEN_CHARS);

    asl_pkg::t_lex_mode                 r_mode, n_mode;
    logic [asl_pkg::VALUE_W-1:0]        r_accum, n_accum;
    logic [asl_pkg::COUNT_W-1:0]        r_count, n_count;
    logic [asl_pkg::LINE_W-1:0]         r_line, n_line;

    // Byte classes
    logic       is_dec, is_upper, is_lower, is_letter, is_hexl, room;
    logic [3:0] dig_val, hex_val;

    assign is_dec    = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign is_upper  = (i_byte >= 8'h41) && (i_byte <= 8'h5A);
    assign is_lower  = (i_byte >= 8'h61) && (i_byte <= 8'h7A);
    assign is_letter = is_upper || is_lower;
    assign is_hexl   = ((i_byte >= 8'h41) && (i_byte <= 8'h46)) ||
                       ((i_byte >= 8'h61) && (i_byte <= 8'h66));
    assign dig_val   = i_byte[3:0];
    assign hex_val   = is_dec ? i_byte[3:0] : 4'(i_byte[3:0] + 4'd9);
    assign room      = r_count < MAX_CNT;

    logic                        close_v, main_v, do_fresh, line_inc;
    asl_pkg::t_tok_kind          close_kind, main_kind;
    logic [asl_pkg::VALUE_W-1:0] close_val, main_val;

    // Next state and results of one beat
    always_comb begin
        n_mode     = r_mode;
        n_accum    = r_accum;
        n_count    = r_count;
        n_line     = r_line;
        close_v    = 1'b0;
        close_kind = asl_pkg::TK_NUMBER;
        close_val  = '0;
        main_v     = 1'b0;
        main_kind  = asl_pkg::TK_EOF;
        main_val   = '0;
        do_fresh   = 1'b0;
        line_inc   = 1'b0;

        if (i_req_eof) begin
            // flush the open token, then end of file
            unique case (r_mode)
                asl_pkg::LM_DEC: begin
                    close_v   = 1'b1;
                    close_val = r_accum;
                end
                asl_pkg::LM_HEX: begin
                    close_v = 1'b1;
                    if (r_count != '0) begin
                        close_val = r_accum;
                    end else begin
                        close_kind = asl_pkg::TK_ERROR;
                    end
                end
                asl_pkg::LM_WORD: begin
                    close_v    = 1'b1;
                    close_kind = asl_pkg::TK_WEND;
                    close_val  = asl_pkg::VALUE_W'(r_count);
                end
                default: close_v = 1'b0;
            endcase
            main_v  = 1'b1;
            n_mode  = asl_pkg::LM_IDLE;
            n_accum = '0;
            n_count = '0;
        end else begin
            unique case (r_mode)
                asl_pkg::LM_CR: begin
                    // byte after CR is swallowed
                    main_v    = 1'b1;
                    main_kind = asl_pkg::TK_NEWLINE;
                    line_inc  = 1'b1;
                    n_mode    = asl_pkg::LM_IDLE;
                    n_accum   = '0;
                    n_count   = '0;
                end
                asl_pkg::LM_DEC: begin
                    if (is_dec && room) begin
                        n_accum = (r_accum << 3) + (r_accum << 1)
                                  + asl_pkg::VALUE_W'(dig_val);
                        n_count = r_count + 1'b1;
                    end else begin
                        close_v   = 1'b1;
                        close_val = r_accum;
                        do_fresh  = 1'b1;
                    end
                end
                asl_pkg::LM_HEX: begin
                    if ((is_dec || is_hexl) && room) begin
                        n_accum = {r_accum[asl_pkg::VALUE_W-5:0], hex_val};
                        n_count = r_count + 1'b1;
                    end else begin
                        close_v   = 1'b1;
                        close_val = r_accum;
                        do_fresh  = 1'b1;
                    end
                end
                asl_pkg::LM_WORD: begin
                    if (is_letter && room) begin
                        n_count   = r_count + 1'b1;
                        main_v    = 1'b1;
                        main_kind = asl_pkg::TK_WCHAR;
                        main_val  = asl_pkg::VALUE_W'(i_byte);
                    end else begin
                        close_v    = 1'b1;
                        close_kind = asl_pkg::TK_WEND;
                        close_val  = asl_pkg::VALUE_W'(r_count);
                        do_fresh   = 1'b1;
                    end
                end
                default: do_fresh = 1'b1;
            endcase

            // lex the byte as if idle
            if (do_fresh) begin
                n_mode  = asl_pkg::LM_IDLE;
                n_accum = '0;
                n_count = '0;
                priority if (i_byte == CH_SPACE || i_byte == CH_TAB) begin
                    main_v = 1'b0;
                end else if (is_dec) begin
                    n_mode  = asl_pkg::LM_DEC;
                    n_accum = asl_pkg::VALUE_W'(dig_val);
                    n_count = asl_pkg::COUNT_W'(1);
                end else if (is_letter) begin
                    n_mode    = asl_pkg::LM_WORD;
                    n_count   = asl_pkg::COUNT_W'(1);
                    main_v    = 1'b1;
                    main_kind = asl_pkg::TK_WCHAR;
                    main_val  = asl_pkg::VALUE_W'(i_byte);
                end else begin
                    main_v = 1'b1;
                    unique case (i_byte)
                        CH_DOLLAR: begin
                            main_v = 1'b0;
                            n_mode = asl_pkg::LM_HEX;
                        end
                        CH_CR: begin
                            main_v = 1'b0;
                            n_mode = asl_pkg::LM_CR;
                        end
                        CH_LF: begin
                            main_kind = asl_pkg::TK_NEWLINE;
                            line_inc  = 1'b1;
                        end
                        CH_COMMA:   main_kind = asl_pkg::TK_COMMA;
                        CH_COLON:   main_kind = asl_pkg::TK_COLON;
                        CH_GREATER: main_kind = asl_pkg::TK_GREATER;
                        CH_LESS:    main_kind = asl_pkg::TK_LESS;
                        CH_POUND:   main_kind = asl_pkg::TK_POUND;
                        CH_LPAREN:  main_kind = asl_pkg::TK_LPAREN;
                        CH_RPAREN:  main_kind = asl_pkg::TK_RPAREN;
                        CH_DOT:     main_kind = asl_pkg::TK_DOT;
                        default:    main_kind = asl_pkg::TK_ERROR;
                    endcase
                end
            end
        end

        if (line_inc) begin
            n_line = r_line + 1'b1;
        end
    end

    // Pack results: the closing token goes first
    always_comb begin
        o_pair.cnt          = {1'b0, close_v} + {1'b0, main_v};
        o_pair.res[0].kind  = close_v ? close_kind : main_kind;
        o_pair.res[0].value = close_v ? close_val : main_val;
        o_pair.res[0].line  = r_line;
        o_pair.res[0].last  = !(close_v && main_v);
        o_pair.res[1].kind  = main_kind;
        o_pair.res[1].value = main_val;
        o_pair.res[1].line  = r_line;
        o_pair.res[1].last  = 1'b1;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= asl_pkg::LM_IDLE;
            r_accum <= '0;
            r_count <= '0;
            r_line  <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_accum <= n_accum;
            r_count <= n_count;
            r_line  <= n_line;
        end
    end

endmodule

>>> sv/asl_out_stage.sv
// Result register: holds the results of one beat and sends them one at a time.
module asl_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,    // take a new pair of results
    input  asl_pkg::t_pair   i_pair,
    output logic             o_free,    // a pair may be loaded this cycle
    output logic             o_tvalid,
    input  logic             i_tready,
    output asl_pkg::t_result o_result
);

    logic             r_vld, n_vld;
    logic             r_two;
    logic             r_sel, n_sel;
    asl_pkg::t_result r_res [2];

    logic fire, shown_last;

    assign fire       = r_vld && i_tready;
    assign shown_last = !r_two || r_sel;
    assign o_free     = !r_vld || (fire && shown_last);
    assign o_tvalid   = r_vld;
    assign o_result   = r_res[r_sel];

    // Control: load a pair or step to its second result
    always_comb begin
        n_vld = r_vld;
        n_sel = r_sel;
        if (i_load) begin
            n_vld = 1'b1;
            n_sel = 1'b0;
        end else if (fire) begin
            if (shown_last) begin
                n_vld = 1'b0;
            end else begin
                n_sel = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_sel <= 1'b0;
        end else begin
            r_vld <= n_vld;
            r_sel <= n_sel;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_two    <= i_pair.cnt[1];
            r_res[0] <= i_pair.res[0];
            r_res[1] <= i_pair.res[1];
        end
    end

endmodule

>>> sv/assembler_source_lexer.sv
// Assembler source lexer top level: input register, lexer step, result register.
//
// Input channel (s): one beat per source byte. tuser = 1 marks end of input,
// in which case tdata is ignored. Output channel (m): one beat per token
// result; tuser carries the token kind, tlast marks the last result caused by
// one input beat.
// Each input beat gives zero, one or two results. A word streams one
// word-char beat per letter and is closed by a word-end beat holding its
// length; numbers give one beat with the 16-bit value.
// An accepted beat is held in the input register and lexed from there, and
// its results are loaded into the result register, if not stalled.
// Throughput: one input beat per cycle unless the result register is full; a
// beat with two results holds it until both leave on the single result port.
// Reset (i_rst_n low, synchronous) empties both registers and sets the
// lexer idle with the line count at zero.
// When the receiver stalls, the result register holds and the input
// register still takes one more beat; tready drops once both are full and
// the waiting beat has results.
module assembler_source_lexer #(
    parameter int MAX_TOKEN_CHARS = 79
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] byte_value
    input  logic        i_s_tuser,   // [0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] token_value, [31:16] line_number
    output logic [3:0]  o_m_tuser,   // [3:0] token_kind
    output logic        o_m_tlast    // last_of_run
);

    logic             r_in_vld;
    logic             r_in_eof;
    logic [7:0]       r_in_byte;
    logic             consume, pair_load, out_free;
    logic             m_fire, m_eof;
    asl_pkg::t_pair   pair;
    asl_pkg::t_result result;

    // A beat leaves the input register when its results fit
    assign consume    = r_in_vld && (out_free || (pair.cnt == 2'd0));
    assign pair_load  = consume && (pair.cnt != 2'd0);
    assign o_s_tready = !r_in_vld || consume;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_eof  <= i_s_tuser;
            r_in_byte <= i_s_tdata;
        end
    end

    asl_lex_core #(
        .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (consume),
        .i_req_eof (r_in_eof),
        .i_byte    (r_in_byte),
        .o_pair    (pair)
    );

    asl_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (pair_load),
        .i_pair   (pair),
        .o_free   (out_free),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_result (result)
    );

    // Output packing
    assign o_m_tdata = {result.line, result.value};
    assign o_m_tuser = result.kind;
    assign o_m_tlast = result.last;

    // Output beat taken, and end of file shown
    assign m_fire = o_m_tvalid && i_m_tready;
    assign m_eof  = o_m_tvalid && (o_m_tuser == asl_pkg::TK_EOF);

    `include "assembler_source_lexer_assert.svh"

    `ASL_ASSERT_NOW(a_load_into_free, pair_load, out_free, "pair loaded over a pending result")
    `ASL_ASSERT_NEXT(a_second_follows, m_fire && !o_m_tlast, o_m_tvalid, "second result lost")
    `ASL_ASSERT_NOW(a_eof_is_last, m_eof, o_m_tlast, "end of file not last of its beat")
    `ASL_ASSERT_NOW(a_consume_held, consume, r_in_vld, "lexer stepped without a beat")

endmodule

>>> verif/asl_token_check.sv
// Token stream checker for the assembler source lexer: predicts results and compares.
module asl_token_check #(
    parameter int MAX_TOKEN_CHARS = 79
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] byte_value
    input  logic        i_s_tuser,   // [0] req_type
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // [15:0] value, [31:16] line
    input  logic [3:0]  i_m_tuser,   // [3:0] kind
    input  logic        i_m_tlast,   // last_of_run
    output int          o_mismatches,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTED = 50;
    localparam int HEX_NONE    = 16;

    // Lexer state as predicted
    asl_pkg::t_lex_mode lex_mode;
    logic [15:0]        number_accum;
    logic [6:0]         char_count;
    logic [15:0]        line_no;

    asl_pkg::t_result   step_tokens[$];
    asl_pkg::t_result   expected_tokens[$];
    int                 mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic bit is_letter(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic bit is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    // digit weight in base 16, HEX_NONE when the byte is not a hex digit
    function automatic int hex_weight(input logic [7:0] b);
        if (is_digit(b)) return int'(b - "0");
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        return HEX_NONE;
    endfunction

    function automatic void emit(input asl_pkg::t_tok_kind kind, input logic [15:0] value);
        asl_pkg::t_result tok;
        tok.kind  = kind;
        tok.value = value;
        tok.line  = line_no;
        tok.last  = 1'b0;
        step_tokens.push_back(tok);
    endfunction

    function automatic void clear_token();
        lex_mode     = asl_pkg::LM_IDLE;
        number_accum = '0;
        char_count   = '0;
    endfunction

    // Lex a byte with no token open
    function automatic void lex_fresh(input logic [7:0] b);
        clear_token();
        if (b == " " || b == "\t") return;
        if (is_digit(b)) begin
            lex_mode     = asl_pkg::LM_DEC;
            number_accum = 16'(b - "0");
            char_count   = 7'd1;
            return;
        end
        if (is_letter(b)) begin
            lex_mode   = asl_pkg::LM_WORD;
            char_count = 7'd1;
            emit(asl_pkg::TK_WCHAR, {8'd0, b});
            return;
        end
        case (b)
            "$": lex_mode = asl_pkg::LM_HEX;
            ",": emit(asl_pkg::TK_COMMA, '0);
            ":": emit(asl_pkg::TK_COLON, '0);
            ">": emit(asl_pkg::TK_GREATER, '0);
            "<": emit(asl_pkg::TK_LESS, '0);
            "#": emit(asl_pkg::TK_POUND, '0);
            "(": emit(asl_pkg::TK_LPAREN, '0);
            ")": emit(asl_pkg::TK_RPAREN, '0);
            ".": emit(asl_pkg::TK_DOT, '0);
            "\n": begin
                emit(asl_pkg::TK_NEWLINE, '0);
                line_no = line_no + 16'd1;
            end
            8'h0D: lex_mode = asl_pkg::LM_CR;
            default: emit(asl_pkg::TK_ERROR, '0);
        endcase
    endfunction

    // One accepted input beat: work out its tokens and queue them
    function automatic void lex_beat(input logic end_of_input, input logic [7:0] b);
        bit room;
        int weight;
        room = int'(char_count) < MAX_TOKEN_CHARS;
        step_tokens.delete();
        if (end_of_input) begin
            case (lex_mode)
                asl_pkg::LM_DEC:  emit(asl_pkg::TK_NUMBER, number_accum);
                asl_pkg::LM_HEX: begin
                    if (char_count != 0) emit(asl_pkg::TK_NUMBER, number_accum);
                    else emit(asl_pkg::TK_ERROR, '0);
                end
                asl_pkg::LM_WORD: emit(asl_pkg::TK_WEND, {9'd0, char_count});
                default: ;
            endcase
            emit(asl_pkg::TK_EOF, '0);
            clear_token();
        end else begin
            case (lex_mode)
                asl_pkg::LM_CR: begin
                    // byte after a carriage return is swallowed
                    emit(asl_pkg::TK_NEWLINE, '0);
                    line_no = line_no + 16'd1;
                    clear_token();
                end
                asl_pkg::LM_DEC: begin
                    if (is_digit(b) && room) begin
                        number_accum = 16'(number_accum * 10 + (b - "0"));
                        char_count   = char_count + 7'd1;
                    end else begin
                        emit(asl_pkg::TK_NUMBER, number_accum);
                        lex_fresh(b);
                    end
                end
                asl_pkg::LM_HEX: begin
                    weight = hex_weight(b);
                    if (weight < HEX_NONE && room) begin
                        number_accum = {number_accum[11:0], 4'(weight)};
                        char_count   = char_count + 7'd1;
                    end else begin
                        emit(asl_pkg::TK_NUMBER, number_accum);
                        lex_fresh(b);
                    end
                end
                asl_pkg::LM_WORD: begin
                    if (is_letter(b) && room) begin
                        char_count = char_count + 7'd1;
                        emit(asl_pkg::TK_WCHAR, {8'd0, b});
                    end else begin
                        emit(asl_pkg::TK_WEND, {9'd0, char_count});
                        lex_fresh(b);
                    end
                end
                default: lex_fresh(b);
            endcase
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED) $display("%0t mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Compare one output beat with the oldest expected token
    task automatic check_token(input logic [31:0] data, input logic [3:0] kind,
                               input logic last);
        asl_pkg::t_result want;
        if (expected_tokens.size() == 0) begin
            report_mismatch($sformatf("unexpected beat kind %0d value %0h line %0d",
                                      kind, data[15:0], data[31:16]));
            return;
        end
        want = expected_tokens.pop_front();
        if (kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
        if (data[15:0] !== want.value)
            report_mismatch($sformatf("value %0h, want %0h (kind %0d)",
                                      data[15:0], want.value, want.kind));
        if (data[31:16] !== want.line)
            report_mismatch($sformatf("line %0d, want %0d", data[31:16], want.line));
        if (last !== want.last)
            report_mismatch($sformatf("tlast %b, want %b (kind %0d)", last, want.last,
                                      want.kind));
    endtask

    // Watch both channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_token();
            line_no = '0;
            expected_tokens.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) check_token(i_m_tdata, i_m_tuser, i_m_tlast);
            if (i_s_tvalid && i_s_tready) lex_beat(i_s_tuser, i_s_tdata);
        end
        o_pending <= expected_tokens.size();
    end

endmodule

>>> verif/tb.sv
// Testbench top for the assembler source lexer: clock, reset, byte stimulus, verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES      = 80;
    localparam int WATCHDOG_CYCLES  = 2000;
    localparam int TAIL_CYCLES      = 12;
    localparam int BYTES_PER_PHASE  = 200;
    localparam logic [7:0] CH_CR    = 8'h0D;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = 8'd0;
    logic        i_s_tuser  = 1'b0;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [31:0] o_m_tdata;
    logic [3:0]  o_m_tuser;
    logic        o_m_tlast;

    int mismatches;
    int pending_tokens;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int bytes_sent     = 0;
    int quiet_cycles   = 0;

    string punct_marks = ",:><#().";
    string hex_digits  = "0123456789abcdefABCDEF";

    assembler_source_lexer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    asl_token_check token_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending_tokens)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: random stalls, plus a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_left = HOLD_CYCLES;
            hold_served++;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready = 1'b0;
        end else begin
            i_m_tready = $urandom_range(99) >= sink_stall_pct;
        end
    end

    // Watchdog: too long without any beat on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Offer one beat, with a random gap first; returns at the next falling edge
    task automatic send_beat(input logic end_of_input, input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = end_of_input;
        i_s_tdata  = b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // Stop sending until every expected token has come out
    task automatic wait_drained();
        i_s_tvalid = 1'b0;
        while (pending_tokens != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] random_letter();
        return 8'(($urandom_range(1) ? "a" : "A") + $urandom_range(25));
    endfunction

    // Source-like text: words, numbers, punctuation, line ends, noise, end marks
    task automatic send_random_source(input int count);
        int target;
        int pick;
        int len;
        target = bytes_sent + count;
        while (bytes_sent < target) begin
            pick = $urandom_range(99);
            // a few tokens run past the length cap
            len  = ($urandom_range(99) < 4) ? $urandom_range(84, 76) : $urandom_range(8, 1);
            if (pick < 22) begin
                for (int i = 0; i < len; i++) send_beat(1'b0, random_letter());
            end else if (pick < 36) begin
                for (int i = 0; i < len; i++) send_beat(1'b0, 8'("0" + $urandom_range(9)));
            end else if (pick < 48) begin
                send_beat(1'b0, "$");
                if (len < 76) len = $urandom_range(5, 0);
                for (int i = 0; i < len; i++)
                    send_beat(1'b0, hex_digits[$urandom_range(hex_digits.len() - 1)]);
            end else if (pick < 68) begin
                send_beat(1'b0, punct_marks[$urandom_range(punct_marks.len() - 1)]);
            end else if (pick < 76) begin
                send_beat(1'b0, $urandom_range(1) ? " " : "\t");
            end else if (pick < 84) begin
                if ($urandom_range(1)) begin
                    send_beat(1'b0, "\n");
                end else begin
                    send_beat(1'b0, CH_CR);
                    send_beat(1'b0, 8'($urandom_range(255)));
                end
            end else if (pick < 95) begin
                send_beat(1'b0, 8'($urandom_range(255)));
            end else begin
                send_beat(1'b1, 8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        string directed_text;
        // decimal wrap, hex closed by a letter, word closed by punctuation,
        // empty hex, carriage return swallowing a mark, the remaining marks, blanks
        directed_text = "99999,$fF0z:$>\015<#(). \t\n@";

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, no idling
        for (int i = 0; i < directed_text.len(); i++) send_beat(1'b0, directed_text[i]);
        send_beat(1'b0, 8'h00);
        send_beat(1'b0, 8'h7F);
        send_beat(1'b0, 8'h80);
        send_beat(1'b0, 8'hFF);
        send_beat(1'b0, "$");
        send_beat(1'b1, 8'hFF);   // empty hex at end of input
        send_beat(1'b0, CH_CR);
        send_beat(1'b1, 8'h00);   // carriage return at end of input
        send_beat(1'b0, "a");
        send_beat(1'b1, 8'h5A);
        send_beat(1'b1, 8'h00);   // repeated end of input
        wait_drained();

        // Receiver holds off while bytes keep coming
        hold_requests++;
        send_random_source(BYTES_PER_PHASE);
        wait_drained();

        src_idle_pct   = 55;
        sink_stall_pct = 0;
        send_random_source(BYTES_PER_PHASE);
        wait_drained();

        src_idle_pct   = 0;
        sink_stall_pct = 55;
        send_random_source(BYTES_PER_PHASE);
        wait_drained();

        src_idle_pct   = 30;
        sink_stall_pct = 30;
        send_random_source(BYTES_PER_PHASE);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_tokens == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
